### design/tcg_pkg.sv
// Shared types, codes and helper functions for the text console grid engine.
// No dependencies; the controller, datapath, top level and checker import this package.
`default_nettype none

package tcg_pkg;

  // Input operation codes
  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd1;

  // Register reset values
  localparam logic [8:0] GRID_COLUMNS_RST = 9'd80;
  localparam logic [7:0] GRID_ROWS_RST    = 8'd25;

  // Character codes
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_MIN = 8'd32;

  // Sent-item count at which the last result slot starts being overwritten
  localparam logic [2:0] SENT_CAP = 3'd7;

  typedef enum logic [1:0] {
    EV_WRITE  = 2'd0,
    EV_SCROLL = 2'd1,
    EV_CLEAR  = 2'd2,
    EV_MOVE   = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    IC_DROP,
    IC_CLEAR,
    IC_CR,
    IC_LF,
    IC_BS,
    IC_TAB,
    IC_PRINT
  } in_class_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_TABQ,
    DP_TABN,
    DP_PUT,
    DP_BS,
    DP_CR,
    DP_LF,
    DP_START_CLEAR,
    DP_START_COPY,
    DP_START_ZERO,
    DP_SWEEP,
    DP_EMIT_SCROLL,
    DP_EMIT_CLEAR,
    DP_FLUSH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLR_START,
    S_CLR,
    S_CLR_EMIT,
    S_CR,
    S_LF,
    S_BS,
    S_TABQ,
    S_TABN,
    S_PUT,
    S_SCR_START,
    S_COPY,
    S_DRAIN,
    S_ZERO,
    S_SCR_EMIT,
    S_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    in_class_t in_class;
    logic      sweep_last;
    logic      row_end;
    logic      col_end;
    logic      put_last;
    logic      tab_empty;
    logic      ch_is_lf;
    logic      rows_one;
    logic      out_free;
  } dp_stat_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] cell_col;
    logic [6:0] cell_row;
    logic [7:0] cell_char;
    logic [7:0] cur_col;
    logic [6:0] cur_row;
    logic       last;
  } out_item_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [8:0] clamp_cols(logic [8:0] raw, logic [8:0] mx);
    return (raw == 9'd0) ? 9'd1 : ((raw > mx) ? mx : raw);
  endfunction

  function automatic logic [7:0] clamp_rows(logic [7:0] raw, logic [7:0] mx);
    return (raw == 8'd0) ? 8'd1 : ((raw > mx) ? mx : raw);
  endfunction

endpackage

`default_nettype wire

### design/tcg_if.sv
// Channel interfaces of the text console grid engine: input, result and
// configuration write. No package dependency.
`default_nettype none

interface tcg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_code;
  modport source (output valid, operation, char_code, input ready);
  modport sink   (input valid, operation, char_code, output ready);
endinterface

interface tcg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] cell_col;
  logic [6:0] cell_row;
  logic [7:0] cell_char;
  logic [7:0] cursor_col;
  logic [6:0] cursor_row;
  logic       last;
  modport source (output valid, event_kind, cell_col, cell_row, cell_char,
                  cursor_col, cursor_row, last, input ready);
  modport sink   (input valid, event_kind, cell_col, cell_row, cell_char,
                  cursor_col, cursor_row, last, output ready);
endinterface

interface tcg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/tcg_ctrl.sv
// Controller state machine: sequences each transaction into datapath commands.
// Depends on tcg_pkg.
`default_nettype none

module tcg_ctrl
  import tcg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output dp_cmd_t   cmd
);

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.op = DP_SWEEP;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LATCH;
          unique case (stat.in_class)
            IC_CLEAR: state_nxt = S_CLR_START;
            IC_CR:    state_nxt = S_CR;
            IC_LF:    state_nxt = S_LF;
            IC_BS:    state_nxt = S_BS;
            IC_TAB:   state_nxt = S_TABQ;
            IC_PRINT: state_nxt = S_PUT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR_START: begin
        cmd.op    = DP_START_CLEAR;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.op = DP_SWEEP;
        if (stat.sweep_last) state_nxt = S_CLR_EMIT;
      end
      S_CLR_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = DP_EMIT_CLEAR;
          state_nxt = S_FLUSH;
        end
      end
      S_CR: begin
        if (stat.out_free) begin
          cmd.op    = DP_CR;
          state_nxt = S_FLUSH;
        end
      end
      S_LF: begin
        if (stat.out_free) begin
          cmd.op    = DP_LF;
          state_nxt = stat.row_end ? S_SCR_START : S_FLUSH;
        end
      end
      S_BS: begin
        if (stat.out_free) begin
          cmd.op    = DP_BS;
          state_nxt = S_FLUSH;
        end
      end
      S_TABQ: begin
        cmd.op    = DP_TABQ;
        state_nxt = S_TABN;
      end
      S_TABN: begin
        cmd.op    = DP_TABN;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (stat.out_free) begin
          cmd.op = DP_PUT;
          priority if (stat.col_end && stat.row_end) state_nxt = S_SCR_START;
          else if (stat.put_last)                    state_nxt = S_FLUSH;
          else                                       state_nxt = S_PUT;
        end
      end
      S_SCR_START: begin
        if (stat.rows_one) begin
          cmd.op    = DP_START_ZERO;
          state_nxt = S_ZERO;
        end else begin
          cmd.op    = DP_START_COPY;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.op = DP_SWEEP;
        if (stat.sweep_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last copied cell lands this cycle
        cmd.op    = DP_START_ZERO;
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        cmd.op = DP_SWEEP;
        if (stat.sweep_last) state_nxt = S_SCR_EMIT;
      end
      S_SCR_EMIT: begin
        if (stat.out_free) begin
          cmd.op = DP_EMIT_SCROLL;
          priority if (stat.ch_is_lf) state_nxt = S_FLUSH;
          else if (stat.tab_empty)    state_nxt = S_FLUSH;
          else                        state_nxt = S_PUT;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.op    = DP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

### design/tcg_dp.sv
// Datapath: configuration, cursor, character grid memory, sweep counters and
// the pending and output result registers. Depends on tcg_pkg.
`default_nettype none

module tcg_dp
  import tcg_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 128,
  parameter int TAB_WIDTH   = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  input  wire logic       in_op,
  input  wire logic [7:0] in_char,
  input  wire logic       cfg_fire,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output out_item_t       out_item,
  output logic            out_valid,
  input  wire logic       out_ready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TLW   = $clog2(TAB_WIDTH + 1);
  localparam int RECIP = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam logic [8:0] MAXC = 9'(MAX_COLUMNS);
  localparam logic [7:0] MAXR = 8'(MAX_ROWS);

  function automatic logic [AW-1:0] addr_of(logic [8:0] c, logic [7:0] r);
    logic [15:0] lin;
    lin = 16'(r) * 16'(MAX_COLUMNS) + 16'(c);
    return lin[AW-1:0];
  endfunction

  logic [7:0]  grid_mem [DEPTH];

  logic [8:0]  cols_raw_r;
  logic [7:0]  rows_raw_r;
  logic [7:0]  cur_col_r, col_nxt;
  logic [6:0]  cur_row_r, row_nxt;
  logic        op_r;
  logic [7:0]  ch_r;
  logic [7:0]  q_r;
  logic [TLW-1:0] tab_left_r;
  logic [8:0]  sc_col_r, lim_col_r;
  logic [7:0]  sc_row_r, lim_row_r;
  logic        sw_copy_r;
  logic        cpy_v_r;
  logic [AW-1:0] cpy_addr_r;
  logic [7:0]  rd_r;
  out_item_t   pend_r, out_r, emit_item, load_item;
  logic        pend_v_r, out_v_r;
  logic [2:0]  sent_r;
  in_class_t   in_cls;

  logic [8:0]  cols_u, cfg_cols, cfg_cu;
  logic [7:0]  rows_u, cfg_rows, cfg_ru;
  logic        col_end, row_end, sweep_col_end, sweep_last, emit;
  logic [7:0]  put_char, bs_col;
  logic [6:0]  bs_row, adv_row;
  logic        we;
  logic [AW-1:0] wa;
  logic [7:0]  wd;
  logic [24:0] tab_prod;
  logic [11:0] tab_rem;
  logic        load_out;

  assign cols_u   = clamp_cols(cols_raw_r, MAXC);
  assign rows_u   = clamp_rows(rows_raw_r, MAXR);
  assign col_end  = ({1'b0, cur_col_r} + 9'd1) >= cols_u;
  assign row_end  = ({1'b0, cur_row_r} + 8'd1) >= rows_u;
  assign adv_row  = row_end ? 7'(rows_u - 8'd1) : cur_row_r + 7'd1;
  assign put_char = (ch_r == CH_TAB) ? CH_SPACE : ch_r;
  assign sweep_col_end = (sc_col_r + 9'd1) >= lim_col_r;
  assign sweep_last    = sweep_col_end && ((sc_row_r + 8'd1) >= lim_row_r);
  assign tab_prod = 25'(cur_col_r) * 25'(RECIP);
  assign tab_rem  = 12'(cur_col_r) - 12'(q_r) * 12'(TAB_WIDTH);

  // Clamped sizes as they stand after a configuration write
  assign cfg_cols = (cfg_index == REG_GRID_COLUMNS) ? cfg_data : cols_raw_r;
  assign cfg_rows = (cfg_index == REG_GRID_ROWS) ? cfg_data[7:0] : rows_raw_r;
  assign cfg_cu   = clamp_cols(cfg_cols, MAXC);
  assign cfg_ru   = clamp_rows(cfg_rows, MAXR);

  // Backspace target cell
  always_comb begin
    bs_col = cur_col_r;
    bs_row = cur_row_r;
    priority if (cur_col_r != 8'd0) begin
      bs_col = cur_col_r - 8'd1;
    end else if (cur_row_r != 7'd0) begin
      bs_row = cur_row_r - 7'd1;
      bs_col = 8'(cols_u - 9'd1);
    end else begin
      bs_col = 8'd0;
    end
  end

  // Cursor update, result item and grid write for the current command
  always_comb begin
    col_nxt   = cur_col_r;
    row_nxt   = cur_row_r;
    emit      = 1'b0;
    emit_item = '0;
    we        = 1'b0;
    wa        = addr_of(sc_col_r, sc_row_r);
    wd        = 8'd0;
    unique case (cmd.op)
      DP_START_CLEAR: begin
        col_nxt = 8'd0;
        row_nxt = 7'd0;
      end
      DP_CR: begin
        col_nxt        = 8'd0;
        emit           = 1'b1;
        emit_item.kind = EV_MOVE;
      end
      DP_LF: begin
        col_nxt        = 8'd0;
        row_nxt        = adv_row;
        emit           = !row_end;
        emit_item.kind = EV_MOVE;
      end
      DP_BS: begin
        col_nxt             = bs_col;
        row_nxt             = bs_row;
        emit                = 1'b1;
        emit_item.kind      = EV_WRITE;
        emit_item.cell_col  = bs_col;
        emit_item.cell_row  = bs_row;
        we = 1'b1;
        wa = addr_of({1'b0, bs_col}, {1'b0, bs_row});
      end
      DP_PUT: begin
        if (col_end) begin
          col_nxt = 8'd0;
          row_nxt = adv_row;
        end else begin
          col_nxt = cur_col_r + 8'd1;
        end
        emit                = 1'b1;
        emit_item.kind      = EV_WRITE;
        emit_item.cell_col  = cur_col_r;
        emit_item.cell_row  = cur_row_r;
        emit_item.cell_char = put_char;
        we = 1'b1;
        wa = addr_of({1'b0, cur_col_r}, {1'b0, cur_row_r});
        wd = put_char;
      end
      DP_SWEEP: begin
        we = !sw_copy_r;
      end
      DP_EMIT_SCROLL: begin
        emit           = 1'b1;
        emit_item.kind = EV_SCROLL;
      end
      DP_EMIT_CLEAR: begin
        emit           = 1'b1;
        emit_item.kind = EV_CLEAR;
      end
      default: begin
      end
    endcase
    // a configuration write saturates the cursor to the new grid size
    if (cfg_fire) begin
      if ((cfg_index == REG_GRID_COLUMNS) || (cfg_index == REG_GRID_ROWS)) begin
        if ({1'b0, cur_col_r} >= cfg_cu) col_nxt = 8'(cfg_cu - 9'd1);
        if ({1'b0, cur_row_r} >= cfg_ru) row_nxt = 7'(cfg_ru - 8'd1);
      end
    end
    emit_item.cur_col = col_nxt;
    emit_item.cur_row = row_nxt;
    // a pending copy takes the write port
    if (cpy_v_r) begin
      we = 1'b1;
      wa = cpy_addr_r;
      wd = rd_r;
    end
  end

  // Grid memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) grid_mem[wa] <= wd;
    rd_r <= grid_mem[addr_of(sc_col_r, sc_row_r)];
  end

  // Configuration and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_raw_r <= GRID_COLUMNS_RST;
      rows_raw_r <= GRID_ROWS_RST;
      cur_col_r  <= 8'd0;
      cur_row_r  <= 7'd0;
    end else begin
      if (cfg_fire && (cfg_index == REG_GRID_COLUMNS)) cols_raw_r <= cfg_data;
      if (cfg_fire && (cfg_index == REG_GRID_ROWS))    rows_raw_r <= cfg_data[7:0];
      cur_col_r <= col_nxt;
      cur_row_r <= row_nxt;
    end
  end

  // Transaction payload and tab count
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      op_r       <= in_op;
      ch_r       <= in_char;
      tab_left_r <= TLW'(1);
    end
    if (cmd.op == DP_TABQ) q_r <= tab_prod[23:16];
    if (cmd.op == DP_TABN) tab_left_r <= TLW'(12'(TAB_WIDTH) - tab_rem);
    if (cmd.op == DP_PUT)  tab_left_r <= tab_left_r - TLW'(1);
  end

  // Sweep counters: reset pass, clear, row copy and last-row zeroing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_col_r  <= 9'd0;
      sc_row_r  <= 8'd0;
      lim_col_r <= MAXC;
      lim_row_r <= MAXR;
      sw_copy_r <= 1'b0;
      cpy_v_r   <= 1'b0;
    end else begin
      cpy_v_r <= (cmd.op == DP_SWEEP) && sw_copy_r;
      unique case (cmd.op)
        DP_START_CLEAR: begin
          sc_col_r  <= 9'd0;
          sc_row_r  <= 8'd0;
          lim_col_r <= cols_u;
          lim_row_r <= rows_u;
          sw_copy_r <= 1'b0;
        end
        DP_START_COPY: begin
          sc_col_r  <= 9'd0;
          sc_row_r  <= 8'd1;
          lim_col_r <= cols_u;
          lim_row_r <= rows_u;
          sw_copy_r <= 1'b1;
        end
        DP_START_ZERO: begin
          sc_col_r  <= 9'd0;
          sc_row_r  <= rows_u - 8'd1;
          lim_col_r <= cols_u;
          lim_row_r <= rows_u;
          sw_copy_r <= 1'b0;
        end
        DP_SWEEP: begin
          if (sweep_col_end) begin
            sc_col_r <= 9'd0;
            sc_row_r <= sc_row_r + 8'd1;
          end else begin
            sc_col_r <= sc_col_r + 9'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cpy_addr_r <= addr_of(sc_col_r, sc_row_r - 8'd1);
  end

  // Hold one result back so the final one can carry last
  assign load_out = (emit && pend_v_r && (sent_r != SENT_CAP)) || (cmd.op == DP_FLUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      sent_r   <= 3'd0;
    end else begin
      if (load_out) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
      if (cmd.op == DP_FLUSH) begin
        pend_v_r <= 1'b0;
        sent_r   <= 3'd0;
      end else if (emit) begin
        pend_v_r <= 1'b1;
        if (load_out) sent_r <= sent_r + 3'd1;
      end
    end
  end

  // Mark the flushed item as the final one of its transaction
  always_comb begin
    load_item      = pend_r;
    load_item.last = (cmd.op == DP_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (emit) pend_r <= emit_item;
    if (load_out) out_r <= load_item;
  end

  assign out_item  = out_r;
  assign out_valid = out_v_r;

  // Input decode and status
  always_comb begin
    priority if (in_op == OP_CLEAR)   in_cls = IC_CLEAR;
    else if (in_char == CH_CR)        in_cls = IC_CR;
    else if (in_char == CH_LF)        in_cls = IC_LF;
    else if (in_char == CH_BS)        in_cls = IC_BS;
    else if (in_char == CH_TAB)       in_cls = IC_TAB;
    else if (in_char >= CH_PRINT_MIN) in_cls = IC_PRINT;
    else                              in_cls = IC_DROP;
  end

  assign stat.in_class   = in_cls;
  assign stat.sweep_last = sweep_last;
  assign stat.row_end    = row_end;
  assign stat.col_end    = col_end;
  assign stat.put_last   = (tab_left_r == TLW'(1));
  assign stat.tab_empty  = (tab_left_r == '0);
  assign stat.ch_is_lf   = (op_r == OP_PUT) && (ch_r == CH_LF);
  assign stat.rows_one   = (rows_u == 8'd1);
  assign stat.out_free   = !out_v_r || out_ready;

endmodule

`default_nettype wire

### design/text_console_grid_engine.sv
// One transaction is in work at a time; a tab writes spaces up to the next tab
// stop. A scroll copies the in-use rows up (row copy, one cell a cycle) and zeroes
// the last row; a clear sweeps the in-use area. After reset a clearing pass over
// MAX_ROWS * MAX_COLUMNS cells holds in_ch.ready low; configuration is taken always.
`default_nettype none

module text_console_grid_engine
  import tcg_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 128,
  parameter int TAB_WIDTH   = 4
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tcg_in_if.sink    in_ch,
  tcg_out_if.source out_ch,
  tcg_cfg_if.sink   cfg_ch
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  tcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcg_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TAB_WIDTH   (TAB_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_ch.operation),
    .in_char   (in_ch.char_code),
    .cfg_fire  (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  // Drive result channel
  assign out_ch.valid      = out_valid;
  assign out_ch.event_kind = out_item.kind;
  assign out_ch.cell_col   = out_item.cell_col;
  assign out_ch.cell_row   = out_item.cell_row;
  assign out_ch.cell_char  = out_item.cell_char;
  assign out_ch.cursor_col = out_item.cur_col;
  assign out_ch.cursor_row = out_item.cur_row;
  assign out_ch.last       = out_item.last;

endmodule

`default_nettype wire

### design/tcg_checker.sv
// Port-level checker for the text console grid engine and its bind.
// Depends on tcg_pkg and the top level's interface ports.
`default_nettype none

module tcg_checker
  import tcg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_operation,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_cell_col,
  input wire logic [6:0] out_cell_row,
  input wire logic [7:0] out_cell_char,
  input wire logic [7:0] out_cursor_col,
  input wire logic [6:0] out_cursor_row,
  input wire logic       out_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_cell_col) && $stable(out_cursor_col) && $stable(out_last))
    else $error("stalled result changed");

  // Clearing pass runs straight after reset
  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input taken during clearing pass");

  // A clear transaction blocks further input while it sweeps
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_CLEAR) |=> !in_ready)
    else $error("input taken during clear");

  // Scroll and clear items carry no cell, clear homes the cursor
  a_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == EV_SCROLL) || (out_kind == EV_CLEAR)) |->
    (out_cell_col == 8'd0) && (out_cell_row == 7'd0) && (out_cell_char == 8'd0))
    else $error("cell fields set on scroll or clear");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == EV_CLEAR) |->
    (out_cursor_col == 8'd0) && (out_cursor_row == 7'd0))
    else $error("clear did not home cursor");

endmodule

bind text_console_grid_engine tcg_checker u_tcg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_operation   (in_ch.operation),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.event_kind),
  .out_cell_col   (out_ch.cell_col),
  .out_cell_row   (out_ch.cell_row),
  .out_cell_char  (out_ch.cell_char),
  .out_cursor_col (out_ch.cursor_col),
  .out_cursor_row (out_ch.cursor_row),
  .out_last       (out_ch.last)
);

`default_nettype wire

### bench/text_console_grid_engine_test.sv
// Self-checking bench for text_console_grid_engine: directed and random console
// traffic, scored against an in-bench model of the grid and cursor.
// Depends on tcg_pkg and the channel interfaces in design/tcg_if.sv.
`default_nettype none

module text_console_grid_engine_test;
  import tcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS      = 256;
  localparam int NROWS      = 128;
  localparam int TABW       = 4;
  localparam int EV_SLOTS   = 8;
  localparam int CYCLE_CAP  = 10_000_000;
  localparam int TAIL_WAIT  = 40;
  localparam int IDLE_PAUSE = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tcg_in_if  in_ch();
  tcg_out_if out_ch();
  tcg_cfg_if cfg_ch();

  text_console_grid_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: grid, cursor, raw register values
  logic [7:0] grid_mem [NROWS][NCOLS];
  int         cur_x;
  int         cur_y;
  logic [8:0] cols_raw;
  logic [7:0] rows_raw;

  out_item_t  pending_events[$];
  out_item_t  step_ev [EV_SLOTS];
  int         step_cnt;

  bit         failed;
  bit         tx_idle;
  bit         rx_idle;
  int         rx_wait;
  int         rx_hold;
  int         cycle_cnt;

  function automatic int cols_in_use();
    if (cols_raw == 9'd0) return 1;
    return (cols_raw > NCOLS) ? NCOLS : int'(cols_raw);
  endfunction

  function automatic int rows_in_use();
    if (rows_raw == 8'd0) return 1;
    return (rows_raw > NROWS) ? NROWS : int'(rows_raw);
  endfunction

  // Record one event with the cursor as it stands now; slot 7 takes overflow
  function automatic void note_event(ev_kind_t kind, int col, int row, logic [7:0] ch);
    out_item_t ev;
    int slot;
    slot = (step_cnt < EV_SLOTS) ? step_cnt : EV_SLOTS - 1;
    ev.kind      = kind;
    ev.cell_col  = col[7:0];
    ev.cell_row  = row[6:0];
    ev.cell_char = ch;
    ev.cur_col   = cur_x[7:0];
    ev.cur_row   = cur_y[6:0];
    ev.last      = 1'b0;
    step_ev[slot] = ev;
    if (step_cnt < EV_SLOTS) step_cnt++;
  endfunction

  // Advance to the next row; scroll the in-use area when it runs off the end
  function automatic bit line_advance();
    int rows;
    int cols;
    rows = rows_in_use();
    cols = cols_in_use();
    cur_x = 0;
    cur_y++;
    if (cur_y >= rows) begin
      for (int r = 1; r < rows; r++)
        for (int c = 0; c < cols; c++) grid_mem[r-1][c] = grid_mem[r][c];
      for (int c = 0; c < cols; c++) grid_mem[rows-1][c] = 8'd0;
      cur_y = rows - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void put_glyph(logic [7:0] ch);
    int col;
    int row;
    bit scr;
    col = cur_x;
    row = cur_y;
    scr = 1'b0;
    grid_mem[row][col] = ch;
    cur_x++;
    if (cur_x >= cols_in_use()) scr = line_advance();
    note_event(EV_WRITE, col, row, ch);
    if (scr) note_event(EV_SCROLL, 0, 0, 8'd0);
  endfunction

  // Work out the events of one accepted transaction and queue them
  function automatic void console_step(logic op, logic [7:0] ch);
    int n;
    step_cnt = 0;
    if (op == OP_CLEAR) begin
      for (int r = 0; r < rows_in_use(); r++)
        for (int c = 0; c < cols_in_use(); c++) grid_mem[r][c] = 8'd0;
      cur_x = 0;
      cur_y = 0;
      note_event(EV_CLEAR, 0, 0, 8'd0);
    end else if (ch == CH_CR) begin
      cur_x = 0;
      note_event(EV_MOVE, 0, 0, 8'd0);
    end else if (ch == CH_LF) begin
      if (line_advance()) note_event(EV_SCROLL, 0, 0, 8'd0);
      else note_event(EV_MOVE, 0, 0, 8'd0);
    end else if (ch == CH_BS) begin
      if (cur_x > 0) cur_x--;
      else if (cur_y > 0) begin
        cur_y--;
        cur_x = cols_in_use() - 1;
      end
      grid_mem[cur_y][cur_x] = 8'd0;
      note_event(EV_WRITE, cur_x, cur_y, 8'd0);
    end else if (ch == CH_TAB) begin
      n = TABW - (cur_x % TABW);
      repeat (n) put_glyph(CH_SPACE);
    end else if (ch >= CH_PRINT_MIN) begin
      put_glyph(ch);
    end
    if (step_cnt > 0) step_ev[step_cnt-1].last = 1'b1;
    for (int i = 0; i < step_cnt; i++) pending_events.push_back(step_ev[i]);
  endfunction

  // Offer one transaction; valid stays high when the next one follows at once
  task automatic send_char(logic op, logic [7:0] ch);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.char_code = ch;
    do @(posedge clk); while (!in_ch.ready);
    console_step(op, ch);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Hold until every expected event has come back, then let the block settle
  task automatic drain_events();
    drop_valid();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    drain_events();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_GRID_COLUMNS) cols_raw = value;
    else rows_raw = value[7:0];
    if (cur_x >= cols_in_use()) cur_x = cols_in_use() - 1;
    if (cur_y >= rows_in_use()) cur_y = rows_in_use() - 1;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 8'($urandom_range(32, 255));
    if (sel < 55) return CH_LF;
    if (sel < 63) return CH_CR;
    if (sel < 71) return CH_BS;
    if (sel < 81) return CH_TAB;
    if (sel < 93) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 5) send_char(OP_CLEAR, 8'($urandom_range(0, 255)));
      else send_char(OP_PUT, pick_char());
    end
  endtask

  // Wraps, tab stops, scroll, backspace and dropped bytes on a 4 x 2 grid
  task automatic test_directed();
    write_reg(REG_GRID_COLUMNS, 9'd4);
    write_reg(REG_GRID_ROWS, 9'd2);
    send_char(OP_PUT, 8'h41);
    send_char(OP_PUT, CH_TAB);
    send_char(OP_PUT, 8'h42);
    send_char(OP_PUT, 8'h43);
    send_char(OP_PUT, 8'hFF);
    send_char(OP_PUT, 8'h7F);
    send_char(OP_PUT, 8'h20);
    send_char(OP_PUT, 8'h44);
    send_char(OP_PUT, 8'h45);
    send_char(OP_PUT, CH_LF);
    send_char(OP_PUT, CH_LF);
    send_char(OP_PUT, CH_CR);
    send_char(OP_PUT, CH_BS);
    send_char(OP_PUT, 8'h00);
    send_char(OP_PUT, 8'h1F);
    send_char(OP_PUT, 8'h46);
    send_char(OP_PUT, CH_BS);
    send_char(OP_CLEAR, 8'hFF);
    send_char(OP_PUT, CH_BS);
    send_char(OP_PUT, CH_TAB);
    send_char(OP_PUT, CH_TAB);
    send_char(OP_CLEAR, 8'h00);
  endtask

  // Zero and oversized registers, the full grid, and a grid shrunk under the cursor
  task automatic test_register_extremes();
    write_reg(REG_GRID_COLUMNS, 9'd0);
    write_reg(REG_GRID_ROWS, 9'd0);
    send_char(OP_PUT, CH_TAB);
    send_char(OP_PUT, 8'h78);
    send_char(OP_PUT, CH_LF);
    send_char(OP_PUT, CH_BS);
    write_reg(REG_GRID_COLUMNS, 9'h1FF);
    write_reg(REG_GRID_ROWS, 9'h1FF);
    send_random(12);
    send_char(OP_PUT, CH_BS);
    send_char(OP_CLEAR, 8'h55);
    write_reg(REG_GRID_COLUMNS, 9'd256);
    write_reg(REG_GRID_ROWS, 9'd128);
    for (int i = 0; i < 30; i++) send_char(OP_PUT, 8'($urandom_range(32, 255)));
    // shrink the grid beneath the cursor
    write_reg(REG_GRID_COLUMNS, 9'd5);
    write_reg(REG_GRID_ROWS, 9'd3);
    send_char(OP_PUT, 8'h61);
    send_char(OP_PUT, CH_BS);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GRID_COLUMNS, 9'($urandom_range(0, 12)));
      write_reg(REG_GRID_ROWS, {1'($urandom_range(0, 1)), 8'($urandom_range(0, 6))});
      tx_idle = (ph != 3);
      rx_idle = (ph != 3);
      send_random(45);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    write_reg(REG_GRID_COLUMNS, 9'd6);
    write_reg(REG_GRID_ROWS, 9'd3);
    tx_idle = 1'b0;
    @(posedge clk);
    rx_hold = 400;
    send_random(25);
    tx_idle = 1'b1;
    drain_events();
    send_random(10);
  endtask

  // Result side: stall at random, compare each accepted result with the oldest event
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_ch.ready = 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_wait <= rx_idle ? int'($urandom_range(0, 11)) : 0;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d col %0d row %0d", $realtime,
                 out_ch.event_kind, out_ch.cell_col, out_ch.cell_row);
        failed <= 1'b1;
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_kind !== want.kind || out_ch.cell_col !== want.cell_col ||
            out_ch.cell_row !== want.cell_row || out_ch.cell_char !== want.cell_char ||
            out_ch.cursor_col !== want.cur_col || out_ch.cursor_row !== want.cur_row ||
            out_ch.last !== want.last) begin
          $display("%0t: mismatch expected kind %0d cell %0d,%0d char %h cursor %0d,%0d last %0d",
                   $realtime, want.kind, want.cell_col, want.cell_row, want.cell_char,
                   want.cur_col, want.cur_row, want.last);
          $display("%0t:          actual   kind %0d cell %0d,%0d char %h cursor %0d,%0d last %0d",
                   $realtime, out_ch.event_kind, out_ch.cell_col, out_ch.cell_row,
                   out_ch.cell_char, out_ch.cursor_col, out_ch.cursor_row, out_ch.last);
          failed <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("text_console_grid_engine test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUT;
    in_ch.char_code = 8'd0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_GRID_COLUMNS;
    cfg_ch.data     = 9'd0;
    failed    = 1'b0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    rx_wait   = 0;
    rx_hold   = 0;
    cycle_cnt = 0;
    cur_x     = 0;
    cur_y     = 0;
    cols_raw  = GRID_COLUMNS_RST;
    rows_raw  = GRID_ROWS_RST;
    for (int r = 0; r < NROWS; r++)
      for (int c = 0; c < NCOLS; c++) grid_mem[r][c] = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    drop_valid();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (!failed) $display("text_console_grid_engine test passed");
    else $display("text_console_grid_engine test failed");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/tcg_pkg.sv
design/tcg_if.sv
design/tcg_ctrl.sv
design/tcg_dp.sv
design/text_console_grid_engine.sv
design/tcg_checker.sv
bench/text_console_grid_engine_test.sv
